// ===== rtl/icnt_pkg.sv =====
// ----------------------------------------------------------------------------
// icnt_pkg: shared types and constants
// Controller states, command/status bundles and result field limits.
// ----------------------------------------------------------------------------
package icnt_pkg;

  localparam int INV_W = 19;
  localparam int CNT_W = 11;
  localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch accepted item, rewind scan index
    logic rd;     // read stored entry at scan index
    logic store;  // append key, or flag overflow when full
    logic emit;   // load result register, clear sequence state
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;      // store holds the maximum number of items
    logic empty;     // nothing stored yet
    logic scan_end;  // scan index is at the last stored entry
    logic last;      // latched item closes the sequence
  } dp_stat_t;

endpackage

// ===== rtl/icnt_in_if.sv =====
// ----------------------------------------------------------------------------
// icnt_in_if: input channel
// Valid/ready channel carrying one sequence element and its last flag.
// ----------------------------------------------------------------------------
interface icnt_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== rtl/icnt_out_if.sv =====
// ----------------------------------------------------------------------------
// icnt_out_if: result channel
// Valid/ready channel carrying the inversion total, item count and overflow.
// ----------------------------------------------------------------------------
interface icnt_out_if;
  import icnt_pkg::*;

  logic             valid;
  logic             ready;
  logic [INV_W-1:0] inversion_count;
  logic [CNT_W-1:0] item_count;
  logic             overflow;

  modport source (output valid, output inversion_count, output item_count,
                  output overflow, input ready);
  modport sink   (input valid, input inversion_count, input item_count,
                  input overflow, output ready);
endinterface

// ===== rtl/inversion_counter.sv =====
// ----------------------------------------------------------------------------
// inversion_counter: streaming inversion counter
// Counts pairs i<j with value[i] > value[j] over a sequence closed by last.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one signed element per item, last marks the end of a sequence.
//   out_ch : one result item per sequence (inversion total, item count,
//            overflow), sent after the item that carries last.
// Timing:
//   An item accepted with values already stored is compared with each of them
//   (skipped when the store is empty or full) before in_ch is ready again:
//   one read per stored value through the single read port of the value RAM,
//   a drain state for the registered read, then a state to append the value.
//   An item carrying last then loads the result register in ST_EMIT.
// Reset:
//   rst_n (synchronous, active low) empties the sequence and drops any
//   pending result. The value RAM needs no clearing; only entries below the
//   stored count are ever read.
// Stall:
//   The result waits in its register while out_ch is stalled; the block
//   keeps taking items of the next sequence and only holds in front of the
//   next result until the register is free.
// Capacity:
//   Beyond MAX_ITEMS values an item is dropped and overflow is set for the
//   rest of the sequence. Counts saturate at their field maxima.
// ----------------------------------------------------------------------------
module inversion_counter #(
  parameter int MAX_ITEMS  = 1024,
  parameter int VALUE_BITS = 32
) (
  input logic       clk,
  input logic       rst_n,
  icnt_in_if.sink   in_ch,
  icnt_out_if.source out_ch
);
  import icnt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: accept -> scan stored values -> append -> optional result
  icnt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // value store, comparator, counters and result register
  icnt_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_value (in_ch.value),
    .in_last  (in_ch.last),
    .res_inv  (out_ch.inversion_count),
    .res_cnt  (out_ch.item_count),
    .res_ovf  (out_ch.overflow)
  );
endmodule

// ===== rtl/icnt_ram.sv =====
// ----------------------------------------------------------------------------
// icnt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module icnt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/icnt_dp.sv =====
// ----------------------------------------------------------------------------
// icnt_dp: inversion counter datapath
// Value store, scan index, compare against the new key, counters, result.
// ----------------------------------------------------------------------------
module icnt_dp #(
  parameter int MAX_ITEMS  = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  icnt_pkg::ctrl_cmd_t          cmd,
  output icnt_pkg::dp_stat_t           stat,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_last,
  output logic [icnt_pkg::INV_W-1:0]   res_inv,
  output logic [icnt_pkg::CNT_W-1:0]   res_cnt,
  output logic                         res_ovf
);
  import icnt_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = (CW > CNT_W) ? CW : CNT_W;

  logic [VALUE_BITS-1:0] key_r;
  logic                  last_r;
  logic [AW-1:0]         idx_r;
  logic                  cmp_en_r;
  logic [CW-1:0]         count_r;
  logic [INV_W-1:0]      total_r;
  logic                  ovf_r;
  logic [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0] key_in;
  logic [XW-1:0]         cnt_x;
  logic [CNT_W-1:0]      cnt_sat;
  logic                  full;

  // flip the sign bit so unsigned order matches signed order
  assign key_in = {~in_value[VALUE_BITS-1], in_value[VALUE_BITS-2:0]};
  assign full   = (count_r == CW'(MAX_ITEMS));

  assign stat.full     = full;
  assign stat.empty    = (count_r == '0);
  assign stat.scan_end = (CW'(idx_r) == count_r - CW'(1));
  assign stat.last     = last_r;

  assign cnt_x   = XW'(count_r);
  assign cnt_sat = (cnt_x > XW'(CNT_MAX)) ? CNT_MAX : cnt_x[CNT_W-1:0];

  icnt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store && !full),
    .waddr (count_r[AW-1:0]),
    .wdata (key_r),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (rdata)
  );

  // item latch and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= key_in;
      last_r <= in_last;
      idx_r  <= '0;
    end else if (cmd.rd) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
      count_r  <= '0;
      total_r  <= '0;
      ovf_r    <= 1'b0;
    end else begin
      cmp_en_r <= cmd.rd;
      if (cmd.emit) begin
        count_r <= '0;
        total_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        // saturating count of stored values greater than the new key
        if (cmp_en_r && (rdata > key_r) && (total_r != INV_MAX)) begin
          total_r <= total_r + INV_W'(1);
        end
        if (cmd.store) begin
          if (full) begin
            ovf_r <= 1'b1;
          end else begin
            count_r <= count_r + CW'(1);
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_inv <= total_r;
      res_cnt <= cnt_sat;
      res_ovf <= ovf_r;
    end
  end
endmodule

// ===== rtl/icnt_ctrl.sv =====
// ----------------------------------------------------------------------------
// icnt_ctrl: inversion counter controller
// Sequences accept, scan, store and result hand-off; owns the result valid.
// ----------------------------------------------------------------------------
module icnt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  icnt_pkg::dp_stat_t  stat,
  output icnt_pkg::ctrl_cmd_t cmd
);
  import icnt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.full || stat.empty) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = stat.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:  cmd.rd = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  cmd.store = 1'b1;
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule
